FILE: hdl/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared types and constants of the delta list timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int unsigned NUM_TIMERS = 10;
  localparam int unsigned LIST_DEPTH = 10;
  localparam int unsigned TICK_MS    = 10;

  localparam int unsigned TIMER_W = 4;
  localparam int unsigned DELTA_W = 16;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned CNT_W   = $clog2(LIST_DEPTH + 1);

  // reciprocal for delay_ms / TICK_MS, exact for every 16-bit dividend
  localparam int unsigned   DIV_SHIFT = MS_W + $clog2(TICK_MS);
  localparam longint unsigned DIV_MUL =
    ((longint'(1) << DIV_SHIFT) + longint'(TICK_MS) - 1) / longint'(TICK_MS);
  localparam int unsigned   MUL_W  = MS_W + 1;
  localparam int unsigned   PROD_W = MS_W + MUL_W;

  typedef struct packed {
    logic               cmd;
    logic [TIMER_W-1:0] timer_index;
    logic [MS_W-1:0]    delay_ms;
  } in_t;

  typedef struct packed {
    logic [9:0]       expired_flags;
    logic             insert_dropped;
    logic [CNT_W-1:0] pending_count;
  } out_t;

  typedef struct packed {
    logic [TIMER_W-1:0] timer;
    logic [DELTA_W-1:0] delta;
  } entry_t;

  // token walking down the chain: searching with the remaining ticks,
  // or carrying a displaced entry towards the tail
  typedef struct packed {
    logic               active;
    logic               carry;
    logic [TIMER_W-1:0] timer;
    logic [DELTA_W-1:0] value;
  } tok_t;

  typedef struct packed {
    logic shl;
    logic dec;
  } cell_ctrl_t;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

endpackage

FILE: hdl/delta_list_timer_queue.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Software timers held as a delta list in a chain of slots.
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_ready_o carries in_data_i: a tick (cmd 0) or a
// set of timer_index to delay_ms (cmd 1). Every input transaction yields one
// output transaction on out_valid_o/out_ready_i with the expired flags, the
// drop indication and the pending count as they stand after the item.
// One item is in work at a time. A set passes S_DIV and S_LAUNCH to S_WALK,
// where the insertion token moves one slot per cycle down the chain until
// it stops at a slot (0 to 9), and then S_FIN. A tick passes S_DEC and
// S_POP, where the expired entries are popped one per cycle, and then
// S_FIN. Ignored sets, drops and empty ticks go straight to S_FIN.
// The output register parts the two sides: the next item is accepted while
// a result waits, and the block stalls only when a second result is ready
// before the first has been taken.
// Reset empties the list and clears all flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module delta_list_timer_queue
  import dltq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_LAUNCH, S_WALK, S_DEC, S_POP, S_FIN
  } state_e;

  state_e                state_q;
  logic [CNT_W-1:0]      count_q;
  logic [NUM_TIMERS-1:0] flags_q;
  logic [TIMER_W-1:0]    idx_q;
  logic [MS_W-1:0]       ms_q;
  logic [PROD_W-1:0]     prod_q;
  logic                  dropped_q;
  tok_t                  launch_q;
  out_t                  out_q;
  logic                  out_valid_q;

  cell_ctrl_t            ctrl;
  entry_t                entries [LIST_DEPTH];
  tok_t                  toks    [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] tok_end;
  logic [LIST_DEPTH-1:0] tok_act;
  logic                  pop_now;

  assign pop_now  = (state_q == S_POP) && (count_q != '0) && (entries[0].delta == '0);
  assign ctrl.shl = pop_now;
  assign ctrl.dec = (state_q == S_DEC);

  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    tok_t   tok_in;
    entry_t nbr;
    if (k == 0) begin : g_head
      assign tok_in = launch_q;
    end else begin : g_body
      assign tok_in = toks[k-1];
    end
    if (k == LIST_DEPTH - 1) begin : g_tail
      assign nbr = entries[k];
    end else begin : g_mid
      assign nbr = entries[k+1];
    end

    dltq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    ((k == 0) ? ctrl : cell_ctrl_t'{shl: ctrl.shl, dec: 1'b0}),
      .valid_i   (32'(k) < 32'(count_q)),
      .nbr_i     (nbr),
      .tok_i     (tok_in),
      .tok_o     (toks[k]),
      .entry_o   (entries[k]),
      .tok_end_o (tok_end[k])
    );
    assign tok_act[k] = toks[k].active;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      idx_q <= in_data_i.timer_index;
      ms_q  <= in_data_i.delay_ms;
    end
    if (state_q == S_DIV) begin
      prod_q <= PROD_W'(ms_q) * PROD_W'(MUL_W'(DIV_MUL));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      flags_q     <= '0;
      dropped_q   <= 1'b0;
      launch_q    <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // in the final state the result register is handled below
      if (out_ready_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          launch_q.active <= 1'b0;
          if (in_valid_i) begin
            dropped_q <= 1'b0;
            if (in_data_i.cmd == CMD_SET) begin
              if (32'(in_data_i.timer_index) >= NUM_TIMERS) begin
                state_q <= S_FIN;
              end else if (32'(count_q) >= LIST_DEPTH) begin
                dropped_q <= 1'b1;
                state_q   <= S_FIN;
              end else begin
                state_q <= S_DIV;
              end
            end else begin
              state_q <= (count_q == '0) ? S_FIN : S_DEC;
            end
          end
        end
        S_DIV: begin
          state_q <= S_LAUNCH;
        end
        S_LAUNCH: begin
          launch_q <= '{active: 1'b1, carry: 1'b0, timer: idx_q,
                        value: DELTA_W'(prod_q >> DIV_SHIFT)};
          state_q  <= S_WALK;
        end
        S_WALK: begin
          launch_q.active <= 1'b0;
          if (|tok_end) begin
            count_q        <= count_q + CNT_W'(1);
            flags_q[idx_q] <= 1'b0;
            state_q        <= S_FIN;
          end
        end
        S_DEC: begin
          state_q <= S_POP;
        end
        S_POP: begin
          if (pop_now) begin
            flags_q[entries[0].timer] <= 1'b1;
            count_q                   <= count_q - CNT_W'(1);
          end else begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.expired_flags  <= 10'(flags_q);
            out_q.insert_dropped <= dropped_q;
            out_q.pending_count  <= count_q;
            out_valid_q          <= 1'b1;
            state_q              <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // only one slot can be the first free one
  a_single_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_end))
    else $error("insertion token ended in more than one slot");

  // at most one token in flight along the chain
  a_single_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({tok_act, launch_q.active}))
    else $error("more than one insertion token in the chain");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= LIST_DEPTH)
    else $error("pending count beyond list depth");

  // a drop is reported only against a full list
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && dropped_q) |-> (32'(count_q) == LIST_DEPTH))
    else $error("insert dropped while list had room");

  // an insertion walk always finishes within the list
  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && !launch_q.active && tok_act == '0) |-> (|tok_end) ||
    $past(|tok_end))
    else $error("insertion token lost");

endmodule

FILE: hdl/dltq_cell.sv
// ----------------------------------------------------------------------------
// dltq_cell
// One list slot: holds an entry, counts its delta down on a decrement, shifts
// towards the head on a pop and passes the insertion token on to the next slot.
// ----------------------------------------------------------------------------
module dltq_cell
  import dltq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       valid_i,
  input  entry_t     nbr_i,
  input  tok_t       tok_i,
  output tok_t       tok_o,
  output entry_t     entry_o,
  output logic       tok_end_o
);

  entry_t entry_q, entry_d;
  tok_t   tok_q, tok_d;

  always_comb begin
    entry_d   = entry_q;
    tok_d     = '0;
    tok_end_o = tok_i.active & ~valid_i;
    if (ctrl_i.dec) begin
      if (entry_q.delta != '0) begin
        entry_d.delta = entry_q.delta - DELTA_W'(1);
      end
    end else if (ctrl_i.shl) begin
      entry_d = nbr_i;
    end else if (tok_i.active) begin
      if (!valid_i) begin
        // first free slot: token comes to rest here
        entry_d.timer = tok_i.timer;
        entry_d.delta = tok_i.value;
      end else if (tok_i.carry) begin
        entry_d.timer = tok_i.timer;
        entry_d.delta = tok_i.value;
        tok_d         = '{active: 1'b1, carry: 1'b1,
                          timer: entry_q.timer, value: entry_q.delta};
      end else if (entry_q.delta > tok_i.value) begin
        // insert here, the old entry keeps only what is left after us
        entry_d.timer = tok_i.timer;
        entry_d.delta = tok_i.value;
        tok_d         = '{active: 1'b1, carry: 1'b1, timer: entry_q.timer,
                          value: entry_q.delta - tok_i.value};
      end else begin
        tok_d = '{active: 1'b1, carry: 1'b0, timer: tok_i.timer,
                  value: tok_i.value - entry_q.delta};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o   = tok_q;
  assign entry_o = entry_q;

endmodule
